// ----- rtl/core/rrm_pkg.sv -----
package rrm_pkg;

  localparam int QueueDepth = 16;
  localparam int NumQueues  = 4;
  localparam int QidW       = 2;
  localparam int SlotW      = 4;
  localparam int CntW       = 5;
  localparam int TagW       = 40;
  localparam int AddrW      = QidW + SlotW;
  localparam int StoreDepth = NumQueues * (2 ** SlotW);

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DRAINED  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    op_e             opcode;
    logic [QidW-1:0] direction;
    logic [TagW-1:0] flight_tag;
  } in_t;

  typedef struct packed {
    logic [TagW-1:0] flight_tag_res;
    status_e         status;
    logic            last;
  } res_t;

  // one update request for the shared pointer and count unit
  typedef struct packed {
    logic            en;
    logic            pop;
    logic [QidW-1:0] qid;
  } qcmd_t;

  typedef struct packed {
    logic    strobe;
    status_e status;
    logic    last;
  } res_ctrl_t;

  typedef logic [NumQueues-1:0][CntW-1:0] cnt_vec_t;

  // drain order: west, south, north, east
  function automatic logic [QidW-1:0] visit_queue(input logic [QidW-1:0] pos);
    logic [QidW-1:0] q;
    case (pos)
      2'd0:    q = 2'd0;
      2'd1:    q = 2'd2;
      2'd2:    q = 2'd1;
      default: q = 2'd3;
    endcase
    return q;
  endfunction

endpackage

// ----- rtl/core/four_queue_round_robin_merge_top.sv -----
// push: result strobed in the cycle after the transfer; a new item every cycle while not busy
// drain: the first tag passes the state register, then the store read and result registers,
//   then one tag per cycle; busy stays high until every held tag is read (one store read each)
// drain of empty queues: status-only result in the cycle after the transfer
// rst_ni async active low clears pointers, counts and the sequencer;
//   the tag store is not cleared, results have no backpressure
module four_queue_round_robin_merge_top
  import rrm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic res_strobe_o,
  output res_t res_o
);

  qcmd_t            qcmd;
  cnt_vec_t         counts;
  logic [AddrW-1:0] slot_addr;
  logic             ram_we;
  logic [TagW-1:0]  rdata;
  res_ctrl_t        res_ctrl;

  rrm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .counts_i   (counts),
    .qcmd_o     (qcmd),
    .ram_we_o   (ram_we),
    .res_ctrl_o (res_ctrl)
  );

  rrm_qstate u_qstate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qcmd_i      (qcmd),
    .counts_o    (counts),
    .slot_addr_o (slot_addr)
  );

  rrm_ram #(
    .Width (TagW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_addr),
    .wdata_i (in_i.flight_tag),
    .re_i    (qcmd.en && qcmd.pop),
    .raddr_i (slot_addr),
    .rdata_o (rdata)
  );

  assign res_strobe_o         = res_ctrl.strobe;
  assign res_o.flight_tag_res = (res_ctrl.status == ST_DRAINED) ? rdata : '0;
  assign res_o.status         = res_ctrl.status;
  assign res_o.last           = res_ctrl.last;

endmodule

// ----- rtl/core/rrm_ram.sv -----
module rrm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rrm_qstate.sv -----
module rrm_qstate
  import rrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qcmd_t             qcmd_i,
  output cnt_vec_t          counts_o,
  output logic [AddrW-1:0]  slot_addr_o
);

  logic [NumQueues-1:0][SlotW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NumQueues-1:0][SlotW-1:0] wr_ptr_q, wr_ptr_d;
  cnt_vec_t                        cnt_q, cnt_d;
  logic [SlotW-1:0]                ptr_cur;
  logic [SlotW-1:0]                ptr_nxt;

  // one pointer is picked, advanced and written back per cycle
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    ptr_cur  = qcmd_i.pop ? rd_ptr_q[qcmd_i.qid] : wr_ptr_q[qcmd_i.qid];
    ptr_nxt  = (ptr_cur == SlotW'(QueueDepth - 1)) ? '0 : ptr_cur + 1'b1;
    if (qcmd_i.en) begin
      if (qcmd_i.pop) begin
        rd_ptr_d[qcmd_i.qid] = ptr_nxt;
        cnt_d[qcmd_i.qid]    = cnt_q[qcmd_i.qid] - 1'b1;
      end else begin
        wr_ptr_d[qcmd_i.qid] = ptr_nxt;
        cnt_d[qcmd_i.qid]    = cnt_q[qcmd_i.qid] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign counts_o    = cnt_q;
  assign slot_addr_o = {qcmd_i.qid, ptr_cur};

endmodule

// ----- rtl/core/rrm_seq.sv -----
module rrm_seq
  import rrm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_t       in_i,
  input  cnt_vec_t  counts_i,
  output qcmd_t     qcmd_o,
  output logic      ram_we_o,
  output res_ctrl_t res_ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      pos_q, pos_d;
  res_ctrl_t       res_q, res_d;
  logic [1:0]      sel_pos;
  logic [1:0]      scan_pos;
  logic [QidW-1:0] sel_qid;
  logic            more;
  logic            sel_last;
  logic            push_full;

  // first non-empty queue at or after the current round position
  always_comb begin
    sel_pos  = pos_q;
    scan_pos = pos_q;
    for (int k = NumQueues - 1; k >= 0; k--) begin
      scan_pos = pos_q + 2'(k);
      if (counts_i[visit_queue(scan_pos)] != '0) begin
        sel_pos = scan_pos;
      end
    end
    sel_qid = visit_queue(sel_pos);
    more    = 1'b0;
    for (int q = 0; q < NumQueues; q++) begin
      if ((2'(q) != sel_qid) && (counts_i[q] != '0)) begin
        more = 1'b1;
      end
    end
    sel_last = !more && (counts_i[sel_qid] == CntW'(1));
  end

  assign push_full = (counts_i[in_i.direction] >= CntW'(QueueDepth));

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    qcmd_o   = '0;
    ram_we_o = 1'b0;
    res_d    = '{strobe: 1'b0, status: ST_DRAINED, last: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (in_i.opcode == OP_PUSH) begin
            res_d.strobe = 1'b1;
            res_d.last   = 1'b1;
            if (push_full) begin
              res_d.status = ST_DROPPED;
            end else begin
              qcmd_o.en    = 1'b1;
              qcmd_o.pop   = 1'b0;
              qcmd_o.qid   = in_i.direction;
              ram_we_o     = 1'b1;
              res_d.status = ST_ACCEPTED;
            end
          end else if (counts_i == '0) begin
            res_d.strobe = 1'b1;
            res_d.last   = 1'b1;
            res_d.status = ST_EMPTY;
          end else begin
            state_d = S_DRAIN;
            pos_d   = '0;
          end
        end
      end
      S_DRAIN: begin
        qcmd_o.en    = 1'b1;
        qcmd_o.pop   = 1'b1;
        qcmd_o.qid   = sel_qid;
        res_d.strobe = 1'b1;
        res_d.status = ST_DRAINED;
        res_d.last   = sel_last;
        pos_d        = sel_pos + 1'b1;
        if (sel_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      res_q   <= res_d;
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign res_ctrl_o = res_q;

`ifndef NO_ASSERTIONS
  a_drain_has_tags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (counts_i != '0))
    else $error("drain running with all queues empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qcmd_o.en && !qcmd_o.pop) |-> (counts_i[qcmd_o.qid] < CntW'(QueueDepth)))
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qcmd_o.en && qcmd_o.pop) |-> (counts_i[qcmd_o.qid] != '0))
    else $error("pop from an empty queue");

  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && sel_last) |=> (state_q == S_IDLE && counts_i == '0))
    else $error("drain did not end after its last tag");
`endif

endmodule

// ----- dv/rrm_merge_checker.sv -----
`timescale 1ns / 1ps

module rrm_merge_checker
  import rrm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  in_t  in_i,
  input  logic res_strobe_i,
  input  res_t res_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [QidW-1:0] DirWest  = 2'd0;
  localparam logic [QidW-1:0] DirNorth = 2'd1;
  localparam logic [QidW-1:0] DirSouth = 2'd2;
  localparam logic [QidW-1:0] DirEast  = 2'd3;
  localparam int MaxPrinted = 40;

  // rounds visit west, south, north, east
  localparam logic [QidW-1:0] RoundSeq [NumQueues] = '{DirWest, DirSouth, DirNorth, DirEast};

  logic [TagW-1:0] tag_slots [NumQueues][QueueDepth];
  int              head      [NumQueues];
  int              tail      [NumQueues];
  int              fill      [NumQueues];
  res_t            expected_tags [$];

  task automatic report_mismatch(input string msg);
    if (fail_count_o < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  function automatic int wrap_next(input int p);
    return (p == QueueDepth - 1) ? 0 : p + 1;
  endfunction

  task automatic predict_merge(input in_t item);
    res_t e;
    int   total;
    int   emitted;
    bit   any;
    logic [QidW-1:0] q;
    e = '0;
    if (item.opcode == OP_PUSH) begin
      q = item.direction;
      if (fill[q] >= QueueDepth) begin
        e.status = ST_DROPPED;
      end else begin
        tag_slots[q][tail[q]] = item.flight_tag;
        tail[q] = wrap_next(tail[q]);
        fill[q]++;
        e.status = ST_ACCEPTED;
      end
      e.last = 1'b1;
      expected_tags.push_back(e);
    end else begin
      total = 0;
      for (int i = 0; i < NumQueues; i++) total += fill[i];
      if (total == 0) begin
        e.status = ST_EMPTY;
        e.last   = 1'b1;
        expected_tags.push_back(e);
      end else begin
        emitted = 0;
        do begin
          any = 1'b0;
          for (int i = 0; i < NumQueues; i++) begin
            q = RoundSeq[i];
            if (fill[q] != 0) begin
              any = 1'b1;
              emitted++;
              e.flight_tag_res = tag_slots[q][head[q]];
              e.status         = ST_DRAINED;
              e.last           = (emitted == total);
              expected_tags.push_back(e);
              head[q] = wrap_next(head[q]);
              fill[q]--;
            end
          end
        end while (any);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      for (int i = 0; i < NumQueues; i++) begin
        head[i] = 0;
        tail[i] = 0;
        fill[i] = 0;
      end
      expected_tags.delete();
      fail_count_o = 0;
    end else begin
      if (res_strobe_i) begin
        if (expected_tags.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: tag %h status %0d last %0b",
                                    res_i.flight_tag_res, res_i.status, res_i.last));
        end else begin
          e = expected_tags.pop_front();
          if (res_i.flight_tag_res !== e.flight_tag_res)
            report_mismatch($sformatf("tag %h, expected %h", res_i.flight_tag_res,
                                      e.flight_tag_res));
          if (res_i.status !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", res_i.status, e.status));
          if (res_i.last !== e.last)
            report_mismatch($sformatf("last %0b, expected %0b", res_i.last, e.last));
        end
      end
      // transfer of a new item
      if (start_i && !busy_i) predict_merge(in_i);
    end
    pending_o = expected_tags.size();
  end

endmodule

// ----- dv/tb_four_queue_round_robin_merge_top.sv -----
`timescale 1ns / 1ps

module tb_four_queue_round_robin_merge_top;
  import rrm_pkg::*;

  localparam int RandomItems = 310;
  localparam int CycleLimit  = 300000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  in_i;
  logic res_strobe_o;
  res_t res_o;
  int   fail_count;
  int   pending;
  int   cycles;
  int   burst_left;
  int   sent;

  four_queue_round_robin_merge_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_i         (in_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  rrm_merge_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .in_i         (in_i),
    .res_strobe_i (res_strobe_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [TagW-1:0] rand_tag();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  // sender works in bursts with random gaps; the item is held until taken
  task automatic issue(input op_e op, input logic [QidW-1:0] dir, input logic [TagW-1:0] tag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start           <= 1'b1;
    in_i.opcode     <= op;
    in_i.direction  <= dir;
    in_i.flight_tag <= tag;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int kind;
    int len;
    int odds;
    logic [QidW-1:0] hot;
    logic [QidW-1:0] dir;
    burst_left = 24;
    sent       = 0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    in_i       = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty drain, all-ones tags in every queue, fill one queue past full
    issue(OP_DRAIN, 2'($urandom), rand_tag());
    for (int d = 0; d < NumQueues; d++) issue(OP_PUSH, 2'(d), '1);
    issue(OP_DRAIN, 2'($urandom), rand_tag());
    hot = 2'($urandom);
    for (int i = 0; i <= QueueDepth; i++) issue(OP_PUSH, hot, rand_tag());
    issue(OP_DRAIN, 2'($urandom), rand_tag());
    wait_drained();

    while (sent < RandomItems) begin
      kind = $urandom_range(0, 4);
      hot  = 2'($urandom);
      case (kind)
        // pushes spread over every queue, more than all of them hold, then one long drain
        0: begin
          for (int i = 0; i < NumQueues * QueueDepth + 4; i++) begin
            dir = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'(i);
            issue(OP_PUSH, dir, rand_tag());
          end
          issue(OP_DRAIN, 2'($urandom), rand_tag());
        end
        default: begin
          case (kind)
            1:       begin len = $urandom_range(20, 40); odds = 8;  end
            2:       begin len = $urandom_range(30, 50); odds = 30; end
            3:       begin len = $urandom_range(10, 20); odds = 2;  end
            default: begin len = $urandom_range(15, 30); odds = 5;  end
          endcase
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(1, odds) == 1) begin
              issue(OP_DRAIN, 2'($urandom), rand_tag());
            end else begin
              // hot queue takes most pushes in the long phases so it overflows
              dir = (kind == 2 && $urandom_range(0, 3) != 0) ? hot : 2'($urandom);
              issue(OP_PUSH, dir, rand_tag());
            end
          end
        end
      endcase
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    issue(OP_DRAIN, 2'($urandom), rand_tag());

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rrm_pkg.sv
rtl/core/rrm_ram.sv
rtl/core/rrm_qstate.sv
rtl/core/rrm_seq.sv
rtl/core/four_queue_round_robin_merge_top.sv
dv/rrm_merge_checker.sv
dv/tb_four_queue_round_robin_merge_top.sv
